[src/htsm_pkg.sv]
// package for the hex tag stream matcher
// holds the phase and verdict codes, the parser state type and the hex decode helper
package htsm_pkg;

  localparam int unsigned CH_W    = 8;
  localparam int unsigned JOB_W   = 64;
  localparam int unsigned PASS_W  = 32;
  localparam int unsigned VERD_W  = 2;
  localparam int unsigned S_DATA_W = 8;
  localparam int unsigned M_DATA_W = 8;

  localparam logic [CH_W-1:0] CH_DASH  = 8'h2d;
  localparam logic [CH_W-1:0] CH_DOT   = 8'h2e;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_LOW_A = 8'h61;
  localparam logic [CH_W-1:0] CH_LOW_F = 8'h66;

  typedef enum logic [0:0] {
    REG_OWN_JOB  = 1'b0,
    REG_OWN_PASS = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_JOB  = 2'd1,
    PH_PASS = 2'd2
  } phase_t;

  typedef enum logic [VERD_W-1:0] {
    VERD_MATCH    = 2'd0,
    VERD_DIFFERS  = 2'd1,
    VERD_BAD_JOB  = 2'd2,
    VERD_BAD_PASS = 2'd3
  } verdict_t;

  typedef struct packed {
    phase_t            phase;
    logic [JOB_W-1:0]  accum;
    logic              digit_seen;
    logic              job_equal;
  } parse_state_t;

  typedef struct packed {
    logic     valid;
    verdict_t verdict;
  } parse_result_t;

  // bit 4 set when the byte is not a lowercase hex digit
  function automatic logic [4:0] hex_value(input logic [CH_W-1:0] ch);
    logic [CH_W-1:0] diff;
    begin
      diff = '0;
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
        diff = ch - CH_ZERO;
        hex_value = {1'b0, diff[3:0]};
      end else if (ch >= CH_LOW_A && ch <= CH_LOW_F) begin
        diff = ch - CH_LOW_A + 8'd10;
        hex_value = {1'b0, diff[3:0]};
      end else begin
        hex_value = 5'h10;
      end
    end
  endfunction

endpackage

[src/htsm_step.sv]
// one parse step of the hex tag matcher: next parser state and optional verdict
// depends on htsm_pkg
module htsm_step
  import htsm_pkg::*;
(
  input  parse_state_t             cur,
  input  logic [CH_W-1:0]          ch,
  input  logic                     first,
  input  logic [JOB_W-1:0]         own_job,
  input  logic [PASS_W-1:0]        own_pass,
  output parse_state_t             nxt,
  output parse_result_t            res
);

  parse_state_t     eff;
  logic [CH_W-1:0]  term;
  verdict_t         bad;
  logic [4:0]       digit;
  logic             pass_equal;

  always_comb begin
    eff = cur;
    if (first) begin
      eff.phase      = PH_JOB;
      eff.accum      = '0;
      eff.digit_seen = 1'b0;
      eff.job_equal  = 1'b0;
    end
  end

  assign digit      = hex_value(ch);
  assign term       = (eff.phase == PH_JOB) ? CH_DASH : CH_DOT;
  assign bad        = (eff.phase == PH_JOB) ? VERD_BAD_JOB : VERD_BAD_PASS;
  assign pass_equal = (eff.accum == {{(JOB_W-PASS_W){1'b0}}, own_pass});

  always_comb begin
    nxt         = eff;
    res.valid   = 1'b0;
    res.verdict = VERD_MATCH;
    unique case (eff.phase)
      PH_JOB, PH_PASS: begin
        if (ch == term) begin
          if (!eff.digit_seen) begin
            res.valid   = 1'b1;
            res.verdict = bad;
            nxt.phase   = PH_IDLE;
          end else if (eff.phase == PH_JOB) begin
            nxt.job_equal  = (eff.accum == own_job);
            nxt.accum      = '0;
            nxt.digit_seen = 1'b0;
            nxt.phase      = PH_PASS;
          end else begin
            res.valid   = 1'b1;
            res.verdict = (eff.job_equal && pass_equal) ? VERD_MATCH : VERD_DIFFERS;
            nxt.phase   = PH_IDLE;
          end
        end else if (digit[4] || (eff.accum[JOB_W-1:JOB_W-4] != 4'd0)) begin
          res.valid   = 1'b1;
          res.verdict = bad;
          nxt.phase   = PH_IDLE;
        end else begin
          nxt.accum      = {eff.accum[JOB_W-5:0], digit[3:0]};
          nxt.digit_seen = 1'b1;
        end
      end
      default: begin
        nxt.phase = PH_IDLE;
      end
    endcase
  end

endmodule

[src/hex_tag_stream_matcher_top.sv]
// top level of the hex tag stream matcher: byte stream in, verdict stream out
// depends on htsm_pkg and htsm_step
//
// usage:
//   s_* carries one name byte per transfer; s_tuser marks the first byte of a
//   name and restarts the parse. the tag "<job>-<pass>." is parsed in lowercase
//   hex and compared with own_job and own_pass, written through cfg_we,
//   cfg_index (0 job, 1 pass) and cfg_data while the stream is idle.
//   m_* carries one verdict per name: on the pass terminator or at the first
//   malformed byte. later bytes of that name give nothing.
//   throughput: one byte per cycle while s_tready is high; the parser state updates in the cycle of
//   the transfer through one level of compare, shift and add logic.
//   verdicts: a verdict is registered from the byte that caused it, then shows on m_tvalid.
//   stall: results sit in an output register backed by one skid entry; s_tready
//   drops only while both are full, so the input keeps moving while one verdict
//   waits.
//   reset: rst clears the parser to idle, drops both result entries and sets
//   own_job and own_pass to zero.
module hex_tag_stream_matcher_top
  import htsm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_DATA_W-1:0]  s_tdata,   // [7:0] ch
  input  logic                 s_tuser,   // [0] first
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_DATA_W-1:0]  m_tdata,   // [0] matched, [2:1] verdict, [7:3] zero
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_index,
  input  logic [JOB_W-1:0]     cfg_data
);

  logic [JOB_W-1:0]   own_job;
  logic [PASS_W-1:0]  own_pass;
  parse_state_t       state;
  parse_state_t       state_next;
  parse_result_t      res;
  logic               in_xfer;
  logic               out_xfer;
  logic               push;
  logic               skid_valid;
  verdict_t           skid_verdict;
  verdict_t           out_verdict;

  htsm_step u_step (
    .cur      (state),
    .ch       (s_tdata[CH_W-1:0]),
    .first    (s_tuser),
    .own_job  (own_job),
    .own_pass (own_pass),
    .nxt      (state_next),
    .res      (res)
  );

  assign s_tready = !skid_valid;
  assign in_xfer  = s_tvalid && s_tready;
  assign out_xfer = m_tvalid && m_tready;
  assign push     = in_xfer && res.valid;

  assign m_tdata = {{(M_DATA_W-VERD_W-1){1'b0}}, out_verdict, out_verdict == VERD_MATCH};

  always_ff @(posedge clk) begin
    if (rst) begin
      own_job  <= '0;
      own_pass <= '0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_OWN_JOB:  own_job  <= cfg_data;
        REG_OWN_PASS: own_pass <= cfg_data[PASS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{phase: PH_IDLE, accum: '0, digit_seen: 1'b0, job_equal: 1'b0};
    end else if (in_xfer) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_xfer) begin
      if (skid_valid) begin
        out_verdict <= skid_verdict;
        skid_valid  <= 1'b0;
      end else if (push) begin
        out_verdict <= res.verdict;
      end else begin
        m_tvalid <= 1'b0;
      end
    end else if (push) begin
      if (!m_tvalid) begin
        out_verdict <= res.verdict;
        m_tvalid    <= 1'b1;
      end else begin
        skid_verdict <= res.verdict;
        skid_valid   <= 1'b1;
      end
    end
  end

endmodule

[src/htsm_checker.sv]
// port level checks for the hex tag stream matcher, bound to the top level
// depends on htsm_pkg
module htsm_checker
  import htsm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [M_DATA_W-1:0]  m_tdata
);

  // nothing to show right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // matched flag agrees with the verdict code
  a_match_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] == (m_tdata[2:1] == VERD_MATCH)))
    else $error("matched flag disagrees with verdict");

  // a new result only follows an input transfer
  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
    else $error("result without input transfer");

  // padding bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[M_DATA_W-1:VERD_W+1] == '0))
    else $error("nonzero padding in result");

endmodule

bind hex_tag_stream_matcher_top htsm_checker u_htsm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
